@@ sv/nfa_pkg.sv @@
package nfa_pkg;

  localparam int ARENA_GRANULES  = 4096;
  localparam int ADDR_W          = 12;
  localparam int TOP_W           = 13;
  localparam int HDR_W           = 15;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_FREED  = 2'd1;
  localparam logic [1:0] KIND_REUSED = 2'd2;
  localparam logic [1:0] KIND_FRESH  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ZERO  = 2'd1;
  localparam logic [1:0] STATUS_SPACE = 2'd2;
  localparam logic [1:0] STATUS_BAD   = 2'd3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] size;
    logic              free;
    logic [1:0]        kind;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_ROVER,
    ST_CUR,
    ST_MERGE,
    ST_NEXT,
    ST_EVAL,
    ST_SPLIT,
    ST_TAKE,
    ST_EXTEND,
    ST_RELEASE,
    ST_RDONE,
    ST_FINISH
  } state_t;

endpackage

@@ sv/nfa_ram.sv @@
module nfa_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/next_fit_heap_allocator.sv @@
// Next-fit heap allocator over 4096 granules of 16 bytes, block headers held in one
// 4096 x 15 header RAM (one write and one registered read port). After reset the block
// runs a clearing pass over all 4096 RAM entries and takes no request until it is done.
// A zero-size allocate returns the zero status, and the first allocate into an empty
// heap grows it directly. Other allocates scan the block headers next-fit from the
// rover, merge each free block they visit with its free next neighbors, and take
// the first block that fits or, when none fits, fall back to growing the heap.
// The scan is bound by the registered read of the header RAM. A result may wait in the
// output register while the next request is taken.
module next_fit_heap_allocator
  import nfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_bytes[15:0], block_address[31:16]
  input  logic [0:0]  s_axis_tuser,  // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // payload_address[15:0]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  state_t state, state_next;
  logic [ADDR_W-1:0] clr_cnt, clr_cnt_next;
  logic [TOP_W-1:0]  heap_top, heap_top_next;
  logic [ADDR_W-1:0] rover, rover_next;
  logic              rover_valid, rover_valid_next;
  logic [TOP_W-1:0]  limit;
  logic              op, op_next;
  logic [TOP_W-1:0]  need, need_next;
  logic [15:0]       rel_addr, rel_addr_next;
  logic [ADDR_W-1:0] rel_g, rel_g_next;
  logic [ADDR_W-1:0] cur, cur_next;
  logic [ADDR_W-1:0] start, start_next;
  logic              pass, pass_next;
  logic              from_scan, from_scan_next;
  hdr_t              hdr, hdr_next;
  logic              dirty, dirty_next;
  logic [15:0]       res_addr, res_addr_next;
  logic [1:0]        res_status, res_status_next;
  logic              out_valid;
  logic [15:0]       out_addr;
  logic [1:0]        out_status;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  hdr_t              wdata, rdata;
  logic [HDR_W-1:0]  rdata_raw;

  logic [16:0]       bytes_rnd;
  logic [13:0]       n_addr;
  logic [13:0]       need_p2;
  logic [TOP_W-1:0]  limit_eff;
  logic              ext_ok;
  logic [11:0]       rel_p;

  nfa_ram #(.WIDTH(HDR_W), .DEPTH(ARENA_GRANULES)) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = hdr_t'(rdata_raw);

  assign bytes_rnd = {1'b0, s_axis_tdata[15:0]} + 17'd15;
  assign n_addr    = {2'b0, cur} + 14'd2 + {2'b0, hdr.size};
  assign need_p2   = {1'b0, need} + 14'd2;
  assign limit_eff = (limit > TOP_W'(ARENA_GRANULES)) ? TOP_W'(ARENA_GRANULES) : limit;
  assign ext_ok    = (heap_top <= limit_eff) &&
                     ({1'b0, limit_eff - heap_top} >= need_p2);
  assign rel_p     = rel_addr[15:4];

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_addr;
  assign m_axis_tuser  = out_status;

  always_comb begin
    state_next       = state;
    clr_cnt_next     = clr_cnt;
    heap_top_next    = heap_top;
    rover_next       = rover;
    rover_valid_next = rover_valid;
    op_next          = op;
    need_next        = need;
    rel_addr_next    = rel_addr;
    rel_g_next       = rel_g;
    cur_next         = cur;
    start_next       = start;
    pass_next        = pass;
    from_scan_next   = from_scan;
    hdr_next         = hdr;
    dirty_next       = dirty;
    res_addr_next    = res_addr;
    res_status_next  = res_status;
    we               = 1'b0;
    waddr            = cur;
    wdata            = hdr;
    raddr            = cur;

    case (state)
      ST_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_cnt;
        wdata        = '0;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (clr_cnt == ADDR_W'(ARENA_GRANULES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_next         = s_axis_tuser[0];
          need_next       = bytes_rnd[16:4];
          rel_addr_next   = s_axis_tdata[31:16];
          res_addr_next   = '0;
          res_status_next = STATUS_OK;
          state_next      = (s_axis_tuser[0] == OP_RELEASE) ? ST_RELEASE : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (need == '0) begin
          res_status_next = STATUS_ZERO;
          state_next      = ST_FINISH;
        end else if (heap_top == '0) begin
          from_scan_next = 1'b0;
          state_next     = ST_EXTEND;
        end else begin
          from_scan_next = 1'b1;
          raddr          = rover;
          state_next     = ST_ROVER;
        end
      end
      ST_ROVER: begin
        if (!rover_valid || ({1'b0, rover} >= heap_top) || (rdata.kind == KIND_NONE)) begin
          rover_next = '0;
          start_next = '0;
          cur_next   = '0;
          raddr      = '0;
        end else begin
          start_next = rover;
          cur_next   = rover;
          raddr      = rover;
        end
        rover_valid_next = 1'b1;
        pass_next        = 1'b0;
        state_next       = ST_CUR;
      end
      ST_CUR: begin
        hdr_next   = rdata;
        dirty_next = 1'b0;
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (hdr.free && (n_addr < {1'b0, heap_top})) begin
          raddr      = n_addr[ADDR_W-1:0];
          state_next = ST_NEXT;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_NEXT: begin
        if (rdata.free) begin
          we            = 1'b1;
          waddr         = n_addr[ADDR_W-1:0];
          wdata         = '0;
          hdr_next.size = hdr.size + ADDR_W'(2) + rdata.size;
          hdr_next.kind = KIND_FREED;
          dirty_next    = 1'b1;
          if (rover == n_addr[ADDR_W-1:0]) begin
            rover_next = cur;
          end
          state_next = ST_MERGE;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (dirty) begin
          we    = 1'b1;
          waddr = cur;
          wdata = hdr;
        end
        if (hdr.free && ({1'b0, hdr.size} >= need)) begin
          rover_next = cur;
          state_next = ST_SPLIT;
        end else if (!pass) begin
          if (n_addr < {1'b0, heap_top}) begin
            cur_next   = n_addr[ADDR_W-1:0];
            raddr      = n_addr[ADDR_W-1:0];
            state_next = ST_CUR;
          end else if (start != '0) begin
            cur_next   = '0;
            raddr      = '0;
            pass_next  = 1'b1;
            state_next = ST_CUR;
          end else begin
            state_next = ST_EXTEND;
          end
        end else if ((n_addr < {2'b0, start}) && (n_addr < {1'b0, heap_top})) begin
          cur_next   = n_addr[ADDR_W-1:0];
          raddr      = n_addr[ADDR_W-1:0];
          state_next = ST_CUR;
        end else begin
          state_next = ST_EXTEND;
        end
      end
      ST_SPLIT: begin
        if ({1'b0, hdr.size} >= need + TOP_W'(3)) begin
          we            = 1'b1;
          waddr         = cur + ADDR_W'(2) + need[ADDR_W-1:0];
          wdata.size    = hdr.size - need[ADDR_W-1:0] - ADDR_W'(2);
          wdata.free    = 1'b1;
          wdata.kind    = KIND_FREED;
          hdr_next.size = need[ADDR_W-1:0];
        end
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        we              = 1'b1;
        waddr           = cur;
        wdata.size      = hdr.size;
        wdata.free      = 1'b0;
        wdata.kind      = KIND_REUSED;
        res_addr_next   = {cur + ADDR_W'(2), 4'b0000};
        res_status_next = STATUS_OK;
        state_next      = ST_FINISH;
      end
      ST_EXTEND: begin
        if (ext_ok) begin
          we            = 1'b1;
          waddr         = heap_top[ADDR_W-1:0];
          wdata.size    = need[ADDR_W-1:0];
          wdata.free    = 1'b0;
          wdata.kind    = KIND_FRESH;
          heap_top_next = heap_top + need + TOP_W'(2);
          if (from_scan) begin
            rover_next       = heap_top[ADDR_W-1:0];
            rover_valid_next = 1'b1;
          end
          res_addr_next   = {heap_top[ADDR_W-1:0] + ADDR_W'(2), 4'b0000};
          res_status_next = STATUS_OK;
        end else begin
          res_addr_next   = '0;
          res_status_next = STATUS_SPACE;
        end
        state_next = ST_FINISH;
      end
      ST_RELEASE: begin
        if (rel_addr == '0) begin
          state_next = ST_FINISH;
        end else if ((rel_addr[3:0] != 4'd0) || (rel_p < 12'd2)) begin
          res_status_next = STATUS_BAD;
          state_next      = ST_FINISH;
        end else if ({1'b0, rel_p - 12'd2} >= heap_top) begin
          res_status_next = STATUS_BAD;
          state_next      = ST_FINISH;
        end else begin
          raddr      = rel_p - 12'd2;
          rel_g_next = rel_p - 12'd2;
          state_next = ST_RDONE;
        end
      end
      ST_RDONE: begin
        if (((rdata.kind != KIND_REUSED) && (rdata.kind != KIND_FRESH)) || rdata.free) begin
          res_status_next = STATUS_BAD;
        end else begin
          we         = 1'b1;
          waddr      = rel_g;
          wdata.size = rdata.size;
          wdata.free = 1'b1;
          wdata.kind = KIND_FREED;
        end
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      heap_top    <= '0;
      rover       <= '0;
      rover_valid <= 1'b0;
      limit       <= 13'd4096;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_cnt     <= clr_cnt_next;
      heap_top    <= heap_top_next;
      rover       <= rover_next;
      rover_valid <= rover_valid_next;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (state == ST_FINISH && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    need       <= need_next;
    rel_addr   <= rel_addr_next;
    rel_g      <= rel_g_next;
    cur        <= cur_next;
    start      <= start_next;
    pass       <= pass_next;
    from_scan  <= from_scan_next;
    hdr        <= hdr_next;
    dirty      <= dirty_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (state == ST_FINISH && (!out_valid || m_axis_tready)) begin
      out_addr   <= res_addr;
      out_status <= res_status;
    end
  end

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    heap_top <= TOP_W'(ARENA_GRANULES))
    else $error("heap top beyond arena");

  a_no_req_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_axis_tready)
    else $error("request taken during clearing pass");

  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tdata == 16'd0))
    else $error("failed request with nonzero address");

  a_scan_op: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> ((op == OP_ALLOC) && rover_valid))
    else $error("scan outside allocate");

endmodule

@@ tb/tb_next_fit_heap_allocator.sv @@
`timescale 1ns / 100ps

module tb_next_fit_heap_allocator;
  import nfa_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] bytes;
    logic [15:0] addr;
  } req_t;

  typedef struct {
    logic [15:0] addr;
    logic [1:0]  status;
  } res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 0;
  logic [12:0] cfg_wdata = '0;

  next_fit_heap_allocator uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // heap shadow
  int unsigned hsize [ARENA_GRANULES+1];
  bit          hfree [ARENA_GRANULES+1];
  logic [1:0]  hkind [ARENA_GRANULES+1];
  int unsigned top_g;
  int unsigned rover;
  bit          rover_set;
  int unsigned limit_g = 4096;

  req_t        pending_q[$];
  res_t        expected_q[$];
  logic [15:0] live_addrs[$];
  req_t        cur_req;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          errors = 0;

  function automatic int unsigned next_blk(int unsigned g);
    return g + 2 + hsize[g];
  endfunction

  function automatic void put_hdr(int unsigned g, int unsigned sz, bit fr, logic [1:0] k);
    hsize[g] = sz;
    hfree[g] = fr;
    hkind[g] = k;
  endfunction

  function automatic void coalesce(int unsigned g);
    int unsigned n;
    while (hfree[g]) begin
      n = next_blk(g);
      if (n >= top_g) break;
      if (!hfree[n]) break;
      put_hdr(g, hsize[g] + 2 + hsize[n], 1, KIND_FREED);
      put_hdr(n, 0, 0, KIND_NONE);
      if (rover_set && rover == n) rover = g;
    end
  endfunction

  function automatic bit find_fit(int unsigned need, output int unsigned found);
    int unsigned start;
    int unsigned cur;
    found = 0;
    if (!rover_set || rover >= top_g || hkind[rover] == KIND_NONE) begin
      rover = 0;
      rover_set = 1;
    end
    start = rover;
    for (cur = start; cur < top_g; cur = next_blk(cur)) begin
      coalesce(cur);
      if (hfree[cur] && hsize[cur] >= need) begin
        rover = cur;
        found = cur;
        return 1;
      end
    end
    for (cur = 0; cur < start && cur < top_g; cur = next_blk(cur)) begin
      coalesce(cur);
      if (hfree[cur] && hsize[cur] >= need) begin
        rover = cur;
        found = cur;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit grow_heap(int unsigned need, output int unsigned made);
    int unsigned lim;
    lim = (limit_g > ARENA_GRANULES) ? ARENA_GRANULES : limit_g;
    made = 0;
    if (top_g > lim || lim - top_g < need + 2) return 0;
    made = top_g;
    put_hdr(top_g, need, 0, KIND_FRESH);
    top_g += need + 2;
    return 1;
  endfunction

  function automatic res_t heap_step(req_t r);
    res_t o;
    int unsigned need, g, have, p;
    o.addr = '0;
    o.status = STATUS_OK;
    g = 0;
    if (r.op == OP_ALLOC) begin
      need = (r.bytes + 15) / 16;
      if (need == 0) o.status = STATUS_ZERO;
      else if (top_g == 0) begin
        if (grow_heap(need, g)) o.addr = 16'((g + 2) * 16);
        else o.status = STATUS_SPACE;
      end else if (find_fit(need, g)) begin
        have = hsize[g];
        if (have >= need + 3) begin
          put_hdr(g + 2 + need, have - need - 2, 1, KIND_FREED);
          have = need;
        end
        put_hdr(g, have, 0, KIND_REUSED);
        o.addr = 16'((g + 2) * 16);
      end else if (grow_heap(need, g)) begin
        rover = g;
        rover_set = 1;
        o.addr = 16'((g + 2) * 16);
      end else o.status = STATUS_SPACE;
    end else if (r.addr != 0) begin
      p = r.addr / 16;
      if (r.addr % 16 != 0 || p < 2) o.status = STATUS_BAD;
      else begin
        g = p - 2;
        if (g >= top_g) o.status = STATUS_BAD;
        else if ((hkind[g] != KIND_REUSED && hkind[g] != KIND_FRESH) || hfree[g])
          o.status = STATUS_BAD;
        else put_hdr(g, hsize[g], 1, KIND_FREED);
      end
    end
    return o;
  endfunction

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    res_t r;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        r = heap_step(cur_req);
        expected_q.push_back(r);
        if (r.addr != 0) begin
          live_addrs.push_back(r.addr);
          if (live_addrs.size() > 200) void'(live_addrs.pop_front());
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_req = pending_q.pop_front();
          s_axis_tdata <= {cur_req.addr, cur_req.bytes};
          s_axis_tuser <= cur_req.op;
          s_axis_tvalid <= 1;
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result addr %h status %0d", m_axis_tdata, m_axis_tuser));
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.addr)
            report($sformatf("payload_address %h, want %h", m_axis_tdata, e.addr));
          if (m_axis_tuser !== e.status)
            report($sformatf("status %0d, want %0d", m_axis_tuser, e.status));
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic push_req(logic op, logic [15:0] bytes, logic [15:0] addr);
    req_t r;
    r.op = op;
    r.bytes = bytes;
    r.addr = addr;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= 13'(v);
    @(posedge clk);
    cfg_we <= 0;
    limit_g = v;
  endtask

  function automatic logic [15:0] pick_live();
    if (live_addrs.size() == 0) return 16'(32);
    return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
  endfunction

  task automatic random_batch(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) push_req(OP_ALLOC, 16'($urandom_range(1, 128)), 16'($urandom));
        else if (sel < 90) push_req(OP_ALLOC, 16'($urandom_range(1, 1024)), 16'($urandom));
        else if (sel < 95) push_req(OP_ALLOC, 16'd0, 16'($urandom));
        else push_req(OP_ALLOC, 16'($urandom), 16'($urandom));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 80) push_req(OP_RELEASE, 16'($urandom), pick_live());
        else if (sel < 90) push_req(OP_RELEASE, 16'($urandom), 16'($urandom));
        else if (sel < 95) push_req(OP_RELEASE, 16'($urandom), 16'd0);
        else push_req(OP_RELEASE, 16'($urandom), pick_live() + 16'd8);
      end
    end
    drain();
  endtask

  initial begin
    foreach (hsize[i]) put_hdr(i, 0, 0, KIND_NONE);
    top_g = 0;
    rover = 0;
    rover_set = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    set_limit(4096);

    // directed
    push_req(OP_ALLOC, 16'd0, 16'hFFFF);
    push_req(OP_ALLOC, 16'hFFFF, 16'd0);
    push_req(OP_ALLOC, 16'd1, 16'd0);
    push_req(OP_ALLOC, 16'd16, 16'd0);
    push_req(OP_ALLOC, 16'd17, 16'd0);
    push_req(OP_ALLOC, 16'd200, 16'd0);
    push_req(OP_ALLOC, 16'd48, 16'd0);
    push_req(OP_RELEASE, 16'hFFFF, 16'd0);
    push_req(OP_RELEASE, 16'd0, 16'd5);
    push_req(OP_RELEASE, 16'd0, 16'd16);
    push_req(OP_RELEASE, 16'd0, 16'hFFF0);
    push_req(OP_RELEASE, 16'd0, 16'd64);
    push_req(OP_RELEASE, 16'd0, 16'd32);
    push_req(OP_RELEASE, 16'd0, 16'd80);
    push_req(OP_RELEASE, 16'd0, 16'd80);
    push_req(OP_RELEASE, 16'd0, 16'd144);
    push_req(OP_ALLOC, 16'd16, 16'd0);
    push_req(OP_RELEASE, 16'd0, 16'd80);
    push_req(OP_ALLOC, 16'd64, 16'd0);
    push_req(OP_ALLOC, 16'd4000, 16'd0);
    drain();

    send_idle = 32;
    recv_idle = 57;
    repeat (20) random_batch(25);
    set_limit(8191);
    send_idle = 57;
    recv_idle = 32;
    repeat (20) random_batch(25);
    set_limit(600);
    send_idle = 0;
    recv_idle = 0;
    repeat (8) random_batch(25);
    set_limit(2);
    repeat (2) random_batch(25);
    set_limit(4096);
    repeat (10) random_batch(25);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1s;
    $display("simulation failed");
    $finish;
  end

endmodule
